/* rtl/lslf_pkg.sv */
package lslf_pkg;

	localparam int MAX_PIXELS = 64;
	localparam int PIX_AW     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [2:0] REG_ACTIVE_COUNT = 3'd0;
	localparam logic [2:0] REG_SPEED        = 3'd1;
	localparam logic [2:0] REG_BRIGHTNESS   = 3'd2;
	localparam logic [2:0] REG_COLOR_RED    = 3'd3;
	localparam logic [2:0] REG_COLOR_GREEN  = 3'd4;
	localparam logic [2:0] REG_COLOR_BLUE   = 3'd5;
	localparam logic [2:0] REG_MIRROR       = 3'd6;

	localparam logic [6:0] ACTIVE_COUNT_RST = 7'd64;
	localparam logic [6:0] SPEED_RST        = 7'd50;
	localparam logic [7:0] BRIGHTNESS_RST   = 8'd180;
	localparam logic [7:0] COLOR_RED_RST    = 8'd0;
	localparam logic [7:0] COLOR_GREEN_RST  = 8'd120;
	localparam logic [7:0] COLOR_BLUE_RST   = 8'd255;

	localparam logic [6:0] SPEED_MIN    = 7'd1;
	localparam logic [6:0] SPEED_MAX    = 7'd100;
	localparam logic [6:0] INTERVAL_MAX = 7'd80;
	localparam logic [15:0] INTERVAL_RECIP = 16'd47664;

	localparam logic [7:0] DECAY_STEP  = 8'd30;
	localparam logic [7:0] FADE_CENTRE = 8'd255;
	localparam logic [7:0] FADE_SIDE   = 8'd175;

	localparam logic [CNT_W-1:0] N_MIN = CNT_W'(2);
	localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_PIXELS);

	typedef struct packed {
		logic [6:0] active_count;
		logic [6:0] interval;
		logic [7:0] brightness;
		logic [7:0] color_red;
		logic [7:0] color_green;
		logic [7:0] color_blue;
		logic       mirror;
	} lslf_cfg_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] n;
	} lslf_cmd_t;

	typedef struct packed {
		logic [5:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} lslf_pix_t;

	function automatic logic [6:0] lslf_interval(input logic [6:0] speed);
		logic [6:0]  s;
		logic [22:0] prod;
		s = speed;
		if (s < SPEED_MIN) s = SPEED_MIN;
		if (s > SPEED_MAX) s = SPEED_MAX;
		prod = 23'(s - SPEED_MIN) * 23'(INTERVAL_RECIP);
		return INTERVAL_MAX - prod[22:16];
	endfunction

	function automatic logic [7:0] lslf_decay(input logic [7:0] v);
		return (v > DECAY_STEP) ? v - DECAY_STEP : 8'd0;
	endfunction

	function automatic logic [7:0] lslf_scale(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] p;
		p = 16'(a) * 16'(b);
		return p[15:8];
	endfunction

endpackage

/* rtl/lslf_cfg.sv */
module lslf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lslf_pkg::APB_AW-1:0] paddr,
	input  logic [lslf_pkg::APB_DW-1:0] pwdata,
	output logic [lslf_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output lslf_pkg::lslf_cfg_t        cfg
);
	import lslf_pkg::*;

	logic [6:0] active_count_q;
	logic [6:0] speed_q;
	logic [6:0] interval_q;
	logic [7:0] brightness_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic       mirror_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= ACTIVE_COUNT_RST;
			speed_q        <= SPEED_RST;
			interval_q     <= lslf_interval(SPEED_RST);
			brightness_q   <= BRIGHTNESS_RST;
			red_q          <= COLOR_RED_RST;
			green_q        <= COLOR_GREEN_RST;
			blue_q         <= COLOR_BLUE_RST;
			mirror_q       <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ACTIVE_COUNT: active_count_q <= pwdata[6:0];
				REG_SPEED: begin
					speed_q    <= pwdata[6:0];
					interval_q <= lslf_interval(pwdata[6:0]);
				end
				REG_BRIGHTNESS:  brightness_q <= pwdata[7:0];
				REG_COLOR_RED:   red_q        <= pwdata[7:0];
				REG_COLOR_GREEN: green_q      <= pwdata[7:0];
				REG_COLOR_BLUE:  blue_q       <= pwdata[7:0];
				REG_MIRROR:      mirror_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ACTIVE_COUNT: prdata = APB_DW'(active_count_q);
			REG_SPEED:        prdata = APB_DW'(speed_q);
			REG_BRIGHTNESS:   prdata = APB_DW'(brightness_q);
			REG_COLOR_RED:    prdata = APB_DW'(red_q);
			REG_COLOR_GREEN:  prdata = APB_DW'(green_q);
			REG_COLOR_BLUE:   prdata = APB_DW'(blue_q);
			REG_MIRROR:       prdata = APB_DW'(mirror_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.active_count = active_count_q;
	assign cfg.interval     = interval_q;
	assign cfg.brightness   = brightness_q;
	assign cfg.color_red    = red_q;
	assign cfg.color_green  = green_q;
	assign cfg.color_blue   = blue_q;
	assign cfg.mirror       = mirror_q;

endmodule

/* rtl/lslf_front.sv */
module lslf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  lslf_pkg::lslf_cfg_t cfg,
	input  logic                push,
	output logic                full,
	input  logic [31:0]         now_ms,
	output lslf_pkg::lslf_cmd_t cmd,
	input  logic                cmd_pop
);
	import lslf_pkg::*;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	logic [31:0]      last_q;
	logic [CNT_W-1:0] cq_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   cnt_q;
	logic [31:0]      elapsed;
	logic             move;
	logic             cq_push;
	logic             cq_pop;
	logic [CNT_W-1:0] n_eff;

	assign full    = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign elapsed = now_ms - last_q;
	assign move    = elapsed > 32'(cfg.interval);
	assign cq_push = push & ~full & move;
	assign cq_pop  = cmd_pop & (cnt_q != '0);

	always_comb begin
		n_eff = cfg.active_count;
		if (n_eff < N_MIN) n_eff = N_MIN;
		if (n_eff > N_MAX) n_eff = N_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cq_push) begin
				last_q   <= now_ms;
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cq_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({cq_push, cq_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cq_push) cq_q[wr_ptr_q] <= n_eff;
	end

	assign cmd.valid = (cnt_q != '0);
	assign cmd.n     = cq_q[rd_ptr_q];

endmodule

/* rtl/lslf_back.sv */
module lslf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lslf_pkg::lslf_cfg_t cfg,
	input  lslf_pkg::lslf_cmd_t cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output lslf_pkg::lslf_pix_t pix
);
	import lslf_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHADE = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;
	localparam logic [1:0] ST_WALK  = 2'd3;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	logic [1:0]       state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] pos_q;
	logic             up_q;
	logic [CNT_W-1:0] centre_q;
	logic [CNT_W-1:0] rd_idx_q;

	logic [7:0] col [3];
	logic [7:0] tc_q [3];
	logic [7:0] ts_q [3];
	logic [7:0] pc_q [3];
	logic [7:0] ps_q [3];

	logic [23:0]           mem [MAX_PIXELS];
	logic [MAX_PIXELS-1:0] written_q;
	logic [23:0]           rdata_s1;
	logic                  written_s1;
	logic                  valid_s1;
	logic [PIX_AW-1:0]     idx_s1;
	logic                  last_s1;

	lslf_pix_t         oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_wr_q;
	logic [OQ_AW-1:0]  oq_rd_q;
	logic [OQ_AW:0]    oq_cnt_q;
	logic              oq_pop;

	logic [CNT_W-1:0] nm1;
	logic [CNT_W-1:0] pos_c;
	logic             up_c;
	logic [CNT_W-1:0] centre_c;
	logic [CNT_W-1:0] next_pos;
	logic             issue;
	logic             walk_done;
	logic [23:0]      cur;
	logic [23:0]      newpix;
	logic [CNT_W-1:0] idx_ext;
	logic             hit_centre;
	logic             hit_side;

	assign col[0] = cfg.color_red;
	assign col[1] = cfg.color_green;
	assign col[2] = cfg.color_blue;

	assign cmd_pop = (state_q == ST_IDLE) & cmd.valid;

	always_comb begin
		nm1 = cmd.n - 1'b1;
		if (pos_q >= nm1) begin
			pos_c = nm1;
			up_c  = 1'b0;
		end else if (pos_q == '0) begin
			pos_c = '0;
			up_c  = 1'b1;
		end else begin
			pos_c = pos_q;
			up_c  = up_q;
		end
		centre_c = cfg.mirror ? nm1 - pos_c : pos_c;
		if (up_c) next_pos = pos_c + 1'b1;
		else if (pos_c != '0) next_pos = pos_c - 1'b1;
		else next_pos = '0;
	end

	assign issue = (state_q == ST_WALK) && (rd_idx_q < n_q)
		&& ((OQ_AW+1)'(oq_cnt_q + (OQ_AW+1)'(valid_s1)) < (OQ_AW+1)'(OQ_DEPTH));
	assign walk_done = (state_q == ST_WALK) && (rd_idx_q == n_q) && !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			up_q     <= 1'b1;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						pos_q   <= next_pos;
						up_q    <= up_c;
						state_q <= ST_SHADE;
					end
				end
				ST_SHADE: state_q <= ST_SCALE;
				ST_SCALE: begin
					rd_idx_q <= '0;
					state_q  <= ST_WALK;
				end
				ST_WALK: begin
					if (issue) rd_idx_q <= rd_idx_q + 1'b1;
					if (walk_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			n_q      <= cmd.n;
			centre_q <= centre_c;
		end
		for (int k = 0; k < 3; k++) begin
			if (state_q == ST_SHADE) begin
				tc_q[k] <= lslf_scale(col[k], FADE_CENTRE);
				ts_q[k] <= lslf_scale(col[k], FADE_SIDE);
			end
			if (state_q == ST_SCALE) begin
				pc_q[k] <= lslf_scale(tc_q[k], cfg.brightness);
				ps_q[k] <= lslf_scale(ts_q[k], cfg.brightness);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_idx_q[PIX_AW-1:0]];
			idx_s1   <= rd_idx_q[PIX_AW-1:0];
			last_s1  <= (rd_idx_q == n_q - 1'b1);
		end
		if (valid_s1) mem[idx_s1] <= newpix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s1 <= 1'b0;
		end else begin
			if (issue) written_s1 <= written_q[rd_idx_q[PIX_AW-1:0]];
			if (valid_s1) written_q[idx_s1] <= 1'b1;
		end
	end

	always_comb begin
		cur        = written_s1 ? rdata_s1 : 24'd0;
		idx_ext    = CNT_W'(idx_s1);
		hit_centre = (idx_ext == centre_q);
		hit_side   = ((idx_ext + 1'b1) == centre_q) || (idx_ext == (centre_q + 1'b1));
		if (hit_centre) newpix = {pc_q[0], pc_q[1], pc_q[2]};
		else if (hit_side) newpix = {ps_q[0], ps_q[1], ps_q[2]};
		else newpix = {lslf_decay(cur[23:16]), lslf_decay(cur[15:8]), lslf_decay(cur[7:0])};
	end

	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop & ~empty;
	assign pix    = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) oq_wr_q <= oq_wr_q + 1'b1;
			if (oq_pop) oq_rd_q <= oq_rd_q + 1'b1;
			case ({valid_s1, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wr_q] <= '{index: 6'(idx_s1), red: newpix[23:16], green: newpix[15:8],
				blue: newpix[7:0], last: last_s1};
		end
	end

endmodule

/* rtl/larson_scanner_led_frame.sv */
// channel   direction  handshake                    payload
// apb       in/out     psel penable pwrite pready   paddr pwdata prdata
// time      in         push full                    now_ms
// pixels    out        empty pop                    pixel_index pixel_red/green/blue frame_end
//
// An item is dropped at once unless more than the move interval has passed since the last move.
// A move passes through the SHADE and SCALE setup states, then streams one pixel per cycle through the frame
// store's single read port while the output queue has room.
// Reset clears the frame store through per-pixel valid bits; no clearing pass.
// Up to two moves queue ahead of the streaming side; pop stalls hold the frame walk.
module larson_scanner_led_frame (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lslf_pkg::APB_AW-1:0] paddr,
	input  logic [lslf_pkg::APB_DW-1:0] pwdata,
	output logic [lslf_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [31:0]                 now_ms,
	output logic                        empty,
	input  logic                        pop,
	output logic [5:0]                  pixel_index,
	output logic [7:0]                  pixel_red,
	output logic [7:0]                  pixel_green,
	output logic [7:0]                  pixel_blue,
	output logic                        frame_end
);
	import lslf_pkg::*;

	lslf_cfg_t cfg;
	lslf_cmd_t cmd;
	logic      cmd_pop;
	lslf_pix_t pix;

	lslf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lslf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.full    (full),
		.now_ms  (now_ms),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	lslf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.cmd_pop (cmd_pop),
		.empty   (empty),
		.pop     (pop),
		.pix     (pix)
	);

	assign pixel_index = pix.index;
	assign pixel_red   = pix.red;
	assign pixel_green = pix.green;
	assign pixel_blue  = pix.blue;
	assign frame_end   = pix.last;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import lslf_pkg::*;

	localparam int RUN_LIMIT     = 6_000_000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 1500;
	localparam int RANDOM_MOVES  = 120;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	class frame_tracker;
		bit [7:0] store_r[MAX_PIXELS];
		bit [7:0] store_g[MAX_PIXELS];
		bit [7:0] store_b[MAX_PIXELS];
		bit [6:0] beam_pos;
		bit beam_up;
		bit [31:0] last_move_ms;
		bit [6:0] cfg_count;
		bit [6:0] cfg_speed;
		bit [7:0] cfg_bright;
		bit [7:0] cfg_red;
		bit [7:0] cfg_green;
		bit [7:0] cfg_blue;
		bit cfg_mirror;
		lslf_pix_t due_pixels[$];
		int faults;

		function new();
			foreach (store_r[i]) begin
				store_r[i] = 8'd0;
				store_g[i] = 8'd0;
				store_b[i] = 8'd0;
			end
			beam_pos = 7'd0;
			beam_up = 1'b1;
			last_move_ms = 32'd0;
			cfg_count = ACTIVE_COUNT_RST;
			cfg_speed = SPEED_RST;
			cfg_bright = BRIGHTNESS_RST;
			cfg_red = COLOR_RED_RST;
			cfg_green = COLOR_GREEN_RST;
			cfg_blue = COLOR_BLUE_RST;
			cfg_mirror = 1'b0;
			faults = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_ACTIVE_COUNT: cfg_count = data[6:0];
				REG_SPEED:        cfg_speed = data[6:0];
				REG_BRIGHTNESS:   cfg_bright = data[7:0];
				REG_COLOR_RED:    cfg_red = data[7:0];
				REG_COLOR_GREEN:  cfg_green = data[7:0];
				REG_COLOR_BLUE:   cfg_blue = data[7:0];
				REG_MIRROR:       cfg_mirror = data[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_ACTIVE_COUNT: return 32'(cfg_count);
				REG_SPEED:        return 32'(cfg_speed);
				REG_BRIGHTNESS:   return 32'(cfg_bright);
				REG_COLOR_RED:    return 32'(cfg_red);
				REG_COLOR_GREEN:  return 32'(cfg_green);
				REG_COLOR_BLUE:   return 32'(cfg_blue);
				REG_MIRROR:       return 32'(cfg_mirror);
				default:          return 32'd0;
			endcase
		endfunction

		function int active_pixels();
			int n;
			n = int'(cfg_count);
			if (n < 2) n = 2;
			if (n > MAX_PIXELS) n = MAX_PIXELS;
			return n;
		endfunction

		function int move_interval();
			int s;
			s = int'(cfg_speed);
			if (s < int'(SPEED_MIN)) s = int'(SPEED_MIN);
			if (s > int'(SPEED_MAX)) s = int'(SPEED_MAX);
			return int'(INTERVAL_MAX) - ((s - 1) * 72) / 99;
		endfunction

		function bit [7:0] shade(bit [7:0] col, bit [7:0] fade);
			int unsigned t;
			t = (int'(col) * int'(fade)) >> 8;
			return 8'((t * int'(cfg_bright)) >> 8);
		endfunction

		function void paint(int idx, int n, bit [7:0] fade);
			if (idx >= n) return;
			store_r[idx] = shade(cfg_red, fade);
			store_g[idx] = shade(cfg_green, fade);
			store_b[idx] = shade(cfg_blue, fade);
		endfunction

		function bit [7:0] fall(bit [7:0] v);
			return (v > DECAY_STEP) ? v - DECAY_STEP : 8'd0;
		endfunction

		function int note_time(bit [31:0] now);
			int n;
			int centre;
			bit [31:0] elapsed;
			lslf_pix_t px;
			n = active_pixels();
			elapsed = now - last_move_ms;
			if (elapsed <= 32'(move_interval())) return 0;
			for (int i = 0; i < n; i++) begin
				store_r[i] = fall(store_r[i]);
				store_g[i] = fall(store_g[i]);
				store_b[i] = fall(store_b[i]);
			end
			if (int'(beam_pos) >= n - 1) begin
				beam_pos = 7'(n - 1);
				beam_up = 1'b0;
			end else if (beam_pos == 7'd0) begin
				beam_up = 1'b1;
			end
			centre = cfg_mirror ? n - 1 - int'(beam_pos) : int'(beam_pos);
			if (centre > 0) paint(centre - 1, n, FADE_SIDE);
			paint(centre, n, FADE_CENTRE);
			paint(centre + 1, n, FADE_SIDE);
			if (beam_up) beam_pos = beam_pos + 7'd1;
			else if (beam_pos != 7'd0) beam_pos = beam_pos - 7'd1;
			last_move_ms = now;
			for (int i = 0; i < n; i++) begin
				px.index = 6'(i);
				px.red = store_r[i];
				px.green = store_g[i];
				px.blue = store_b[i];
				px.last = (i == n - 1);
				due_pixels.push_back(px);
			end
			return n;
		endfunction

		function void check_pixel(logic [5:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
				logic last);
			lslf_pix_t want;
			if (due_pixels.size() == 0) begin
				$error("pixel %0d arrived with no frame pending", idx);
				faults++;
				return;
			end
			want = due_pixels.pop_front();
			if (idx !== want.index) begin
				$error("pixel_index expected %0d got %0d", want.index, idx);
				faults++;
			end
			if (r !== want.red) begin
				$error("pixel_red expected %0d got %0d", want.red, r);
				faults++;
			end
			if (g !== want.green) begin
				$error("pixel_green expected %0d got %0d", want.green, g);
				faults++;
			end
			if (b !== want.blue) begin
				$error("pixel_blue expected %0d got %0d", want.blue, b);
				faults++;
			end
			if (last !== want.last) begin
				$error("frame_end expected %0d got %0d", want.last, last);
				faults++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [31:0] now_ms = 32'd0;
	logic empty;
	logic pop = 1'b0;
	logic [5:0] pixel_index;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;
	logic frame_end;

	frame_tracker tracker;
	int cycle_count = 0;
	int moves_done = 0;
	int hold_req = 0;
	bit calm_send = 1'b0;
	bit calm_recv = 1'b0;

	larson_scanner_led_frame uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.pixel_index(pixel_index),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue),
		.frame_end(frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("larson_scanner_led_frame regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			tracker.check_pixel(pixel_index, pixel_red, pixel_green, pixel_blue, frame_end);
	end

	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				idle = hold_req;
				hold_req = 0;
			end
			if (idle > 0) begin
				pop <= 1'b0;
				idle--;
			end else begin
				pop <= 1'b1;
				idle = pick_gap(calm_recv);
			end
		end
	end

	task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] data,
			output logic [31:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		logic [31:0] rd;
		apb_cycle(1'b1, idx, data, rd);
		tracker.set_reg(idx, data);
		if (idx <= REG_MIRROR) begin
			apb_cycle(1'b0, idx, 32'd0, rd);
			if (rd !== tracker.reg_value(idx)) begin
				$error("prdata of register %0d expected %0h got %0h", idx,
					tracker.reg_value(idx), rd);
				tracker.faults++;
			end
		end
	endtask

	task automatic pause_sender();
		int g;
		g = pick_gap(calm_send);
		if (g > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic send_time(input logic [31:0] t);
		@(negedge clk);
		push <= 1'b1;
		now_ms <= t;
		do @(posedge clk); while (full);
		if (tracker.note_time(t) > 0) moves_done++;
		pause_sender();
	endtask

	// drop push, drain every pending pixel, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (tracker.due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_time();
		int r;
		int iv;
		logic [31:0] base;
		iv = tracker.move_interval();
		base = tracker.last_move_ms;
		r = $urandom_range(0, 99);
		if (r < 50) return base + 32'(iv) + 32'd1 + 32'($urandom_range(0, 20));
		if (r < 60) return base + 32'(iv) + 32'd1;
		if (r < 70) return base + 32'(iv);
		if (r < 80) return base + 32'($urandom_range(0, iv - 1));
		if (r < 92) return $urandom();
		return 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
	endfunction

	task automatic rand_config();
		logic [31:0] d;
		int r;
		d = $urandom();
		r = $urandom_range(0, 9);
		if (r < 5) d[6:0] = 7'($urandom_range(2, 8));
		else if (r < 7) d[6:0] = 7'($urandom_range(2, 64));
		else if (r == 7) d[6:0] = 7'($urandom_range(0, 1));
		else if (r == 8) d[6:0] = 7'd64;
		else d[6:0] = 7'($urandom_range(65, 127));
		cfg_write(REG_ACTIVE_COUNT, d);
		d = $urandom();
		r = $urandom_range(0, 9);
		if (r == 0) d[6:0] = 7'd0;
		else if (r == 1) d[6:0] = SPEED_MIN;
		else if (r == 2) d[6:0] = SPEED_MAX;
		else if (r == 3) d[6:0] = 7'($urandom_range(101, 127));
		else d[6:0] = 7'($urandom_range(1, 100));
		cfg_write(REG_SPEED, d);
		for (int k = 0; k < 4; k++) begin
			d = $urandom();
			r = $urandom_range(0, 5);
			if (r == 0) d[7:0] = 8'd0;
			else if (r == 1) d[7:0] = 8'd255;
			case (k)
				0: cfg_write(REG_BRIGHTNESS, d);
				1: cfg_write(REG_COLOR_RED, d);
				2: cfg_write(REG_COLOR_GREEN, d);
				default: cfg_write(REG_COLOR_BLUE, d);
			endcase
		end
		cfg_write(REG_MIRROR, $urandom());
		if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, $urandom());
	endtask

	initial begin
		logic [31:0] times[$];
		logic [31:0] base;
		int phase;
		int start;
		int goal;
		tracker = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		times = '{32'd0, 32'd45, 32'd46, 32'd91, 32'd92, 32'hFFFF_FFFF, 32'd0, 32'd46,
			32'hAAAA_AAAA, 32'h5555_5555};
		foreach (times[i]) send_time(times[i]);
		settle();

		// shrink to two pixels so the beam position saturates, all channels full scale
		cfg_write(REG_ACTIVE_COUNT, 32'hFFFF_FF80);
		cfg_write(REG_SPEED, 32'hFFFF_FF80);
		cfg_write(REG_BRIGHTNESS, 32'hFFFF_FFFF);
		cfg_write(REG_COLOR_RED, 32'h0000_00FF);
		cfg_write(REG_COLOR_GREEN, 32'h0000_00FF);
		cfg_write(REG_COLOR_BLUE, 32'h0000_00FF);
		cfg_write(REG_MIRROR, 32'hFFFF_FFFF);
		base = 32'h5555_5555;
		for (int k = 1; k <= 4; k++) send_time(base + 32'(81 * k));
		settle();

		cfg_write(REG_ACTIVE_COUNT, 32'h0000_007F);
		cfg_write(REG_SPEED, 32'h0000_007F);
		cfg_write(REG_BRIGHTNESS, 32'h0000_0000);
		cfg_write(REG_COLOR_RED, 32'h0000_00A5);
		cfg_write(REG_COLOR_GREEN, 32'h0000_005A);
		cfg_write(REG_COLOR_BLUE, 32'h0000_0000);
		cfg_write(REG_MIRROR, 32'h0000_0000);
		cfg_write(REG_UNUSED, 32'hDEAD_BEEF);
		base = 32'h5555_5555 + 32'd324;
		times = '{base + 32'd8, base + 32'd17, base + 32'd26, 32'hFFFF_FFFC, 32'h0000_0005,
			32'h0000_000D};
		foreach (times[i]) send_time(times[i]);
		settle();

		start = moves_done;
		phase = 0;
		while (moves_done - start < RANDOM_MOVES) begin
			rand_config();
			calm_send = ($urandom_range(0, 3) == 0);
			calm_recv = ($urandom_range(0, 3) == 0);
			if (phase == 1) begin
				calm_send = 1'b1;
				hold_req = HOLD_CYCLES;
			end
			goal = moves_done + $urandom_range(12, 30);
			while (moves_done < goal) send_time(pick_time());
			settle();
			phase++;
		end

		if (tracker.faults == 0 && tracker.due_pixels.size() == 0) begin
			$display("larson_scanner_led_frame regression: pass");
		end else begin
			$display("larson_scanner_led_frame regression: fail");
		end
		$finish;
	end

endmodule
